### rtl/pscc_pkg.sv
package pscc_pkg;

   localparam int MAX_LEN  = 64;
   localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int CHAR_W   = 8;
   localparam int ENDING_W = 7;
   localparam int TOTAL_W  = 12;
   localparam int SUM_W    = ((TOTAL_W > LEN_W) ? TOTAL_W : LEN_W) + 1;

   localparam logic [SUM_W-1:0] ENDING_MAX = SUM_W'((1 << ENDING_W) - 1);
   localparam logic [SUM_W-1:0] TOTAL_MAX  = SUM_W'((1 << TOTAL_W) - 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT  = LEN_W'(MAX_LEN);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(MAX_LEN - 1);

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [ENDING_W-1:0] ending_here;
      logic [TOTAL_W-1:0]  total_count;
      logic                overflow;
      logic                done_res;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  pos;
   } scan_cmd_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] count;
   } scan_sts_type;

endpackage

### rtl/palindromic_substring_counter_unit.sv
// palindromic substring counter
// req channel: one character per beat (ch, last). rsp channel: one beat per
// request beat with the palindromes ending at that character, the running
// total for the string, the sticky overflow flag and a copy of last.
// a beat with last set closes the string; after its response is loaded the
// length, total and overflow flag return to zero for the next string.
// characters beyond 64 in one string are dropped and set overflow.
// req_ready is high only while no character is in work, so one character is
// processed at a time. the scan reads the character and column memories once
// per stored position, one position per cycle, through registered reads. a
// dropped character skips the scan. the next request is taken the cycle after
// the response register is loaded.
// the response register holds while rsp_ready is low; a finished result
// waits in the done state until the register frees up, and req_ready stays low.
// reset clears the control state, length, total and overflow; the memories
// are not cleared, and values from unwritten positions are never used.
module palindromic_substring_counter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pscc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pscc_pkg::rsp_type rsp_data
);
   import pscc_pkg::*;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;
   logic [ENDING_W-1:0] end_ff, end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   scan_cmd_type      cmd;
   scan_sts_type      sts;

   logic              req_fire;
   logic              full;
   logic              load_rsp;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  cnt_ext;

   pscc_column u_column (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   assign req_fire = req_valid && req_ready;
   assign full     = (len_ff >= LEN_LIMIT);
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign cnt_ext  = SUM_W'(sts.count);
   assign sum      = SUM_W'(total_ff) + cnt_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = full ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.start    = 1'b0;
      cmd.ch       = req_data.ch;
      cmd.pos      = len_ff[IDX_W-1:0];
      len_in       = len_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_in = req_data.last;
               if (full) begin
                  ovf_in = 1'b1;
                  end_in = '0;
               end else begin
                  cmd.start = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (sts.done) begin
               len_in   = len_ff + LEN_W'(1);
               total_in = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
               end_in   = (cnt_ext > ENDING_MAX) ? ENDING_MAX[ENDING_W-1:0]
                                                 : cnt_ext[ENDING_W-1:0];
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ending_here = end_ff;
               rsp_in.total_count = total_ff;
               rsp_in.overflow    = ovf_ff;
               rsp_in.done_res    = last_ff;
               if (last_ff) begin
                  len_in   = '0;
                  total_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      end_ff  <= end_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/pscc_column.sv
module pscc_column (
   input  logic                  clock,
   input  logic                  reset,
   input  pscc_pkg::scan_cmd_type cmd,
   output pscc_pkg::scan_sts_type sts
);
   import pscc_pkg::*;

   logic [CHAR_W-1:0] char_mem [MAX_LEN];
   logic              pal_mem  [MAX_LEN];

   logic              issue_on_ff, issue_on_in;
   logic [IDX_W-1:0]  iss_ff, iss_in;
   logic              stg_v_ff, stg_v_in;
   logic [IDX_W-1:0]  stg_idx_ff, stg_idx_in;
   logic [CHAR_W-1:0] c_ff, c_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [CHAR_W-1:0] rd_char_ff;
   logic              rd_pal_ff;
   logic [IDX_W-1:0]  pal_addr;
   logic              hit;
   logic              at_end;

   // inner span starts one past the issued position
   assign pal_addr = (iss_ff == IDX_LAST) ? iss_ff : iss_ff + IDX_W'(1);

   assign at_end = (stg_idx_ff == j_ff);
   assign hit = stg_v_ff &&
                (at_end ||
                 ((rd_char_ff == c_ff) &&
                  ((({1'b0, stg_idx_ff} + (IDX_W+1)'(1)) == {1'b0, j_ff}) || rd_pal_ff)));

   always_comb begin
      issue_on_in = issue_on_ff;
      iss_in      = iss_ff;
      c_in        = c_ff;
      j_in        = j_ff;
      cnt_in      = cnt_ff;
      stg_v_in    = issue_on_ff;
      stg_idx_in  = iss_ff;
      if (cmd.start) begin
         issue_on_in = 1'b1;
         iss_in      = '0;
         c_in        = cmd.ch;
         j_in        = cmd.pos;
         cnt_in      = '0;
      end else begin
         if (issue_on_ff) begin
            iss_in = iss_ff + IDX_W'(1);
            if (iss_ff == j_ff) begin
               issue_on_in = 1'b0;
            end
         end
         if (hit) begin
            cnt_in = cnt_ff + LEN_W'(1);
         end
      end
   end

   assign sts.done  = stg_v_ff && at_end;
   assign sts.count = cnt_ff + LEN_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
         stg_v_ff    <= 1'b0;
      end else begin
         issue_on_ff <= issue_on_in;
         stg_v_ff    <= stg_v_in;
      end
      iss_ff     <= iss_in;
      stg_idx_ff <= stg_idx_in;
      c_ff       <= c_in;
      j_ff       <= j_in;
      cnt_ff     <= cnt_in;
   end

   // character store
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         char_mem[cmd.pos] <= cmd.ch;
      end
      if (issue_on_ff) begin
         rd_char_ff <= char_mem[iss_ff];
      end
   end

   // palindrome column
   always_ff @(posedge clock) begin
      if (stg_v_ff) begin
         pal_mem[stg_idx_ff] <= hit;
      end
      if (issue_on_ff) begin
         rd_pal_ff <= pal_mem[pal_addr];
      end
   end

endmodule
